FILE: hw/rtl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

   localparam int MAX_WIDTH_DEF = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int MIN_DIM       = 3;
   localparam int ROW_W         = 8;
   localparam int DIM_W         = 9;
   localparam int CSR_IDX_W     = 8;
   localparam int SUM_W         = 12;

   // floor(s / 9) == (s * 3641) >> 15 for every s below 2**15
   localparam logic [SUM_W-1:0] DIV9_MULT  = 12'd3641;
   localparam int               DIV9_SHIFT = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 8'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       start_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       row_end;
      logic       frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // [row][col], row 0 is the oldest line, col 2 the newest pixel
   typedef rgb_type [2:0][2:0] window_type;

   typedef logic [8:0][7:0] taps_type;

   typedef struct packed {
      logic valid;
      logic row_end;
      logic frame_end;
   } stage_ctl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/box_blur_3x3_rgb_core.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_data  (rgb pixel, start_of_frame)
// rsp      out        rsp_valid/rsp_ready  rsp_data  (rgb average, row_end, frame_end)
// csr      in         csr_valid/csr_ready  csr_index, csr_data (line_width, frame_height)
//
// One pixel per clock sustained while rsp is not stalled. The edge that accepts a
// request registers the line store read; the window shift, lane sum, and reciprocal
// multiply into the output register follow as registered stages in that order.
// Reset is synchronous; line stores are not cleared, window and counters are.
// Each stage moves when the one after it is empty or moving, so bubbles close
// up and req_ready only drops once rsp stalls with the pipeline full.
`default_nettype none

module box_blur_3x3_rgb_core
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DIM_W-1:0]      csr_data
);

   logic [DIM_W-1:0] line_width_ff;
   logic [DIM_W-1:0] frame_height_ff;

   stage_ctl_type    s2_ctl;
   window_type       window;
   taps_type         red_taps, green_taps, blue_taps;
   logic [7:0]       red_avg, green_avg, blue_avg;

   logic             s3_valid_ff;
   logic             s3_row_end_ff;
   logic             s3_frame_end_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_data_ff;
   logic             en_out, en_s3;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= DIM_RESET;
         frame_height_ff <= DIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign en_out = !rsp_valid_ff || rsp_ready;
   assign en_s3  = !s3_valid_ff || en_out;

   bb3_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .s2_take      (en_s3),
      .s2_ctl       (s2_ctl),
      .window       (window)
   );

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            red_taps[r*3+c]   = window[r][c].red;
            green_taps[r*3+c] = window[r][c].green;
            blue_taps[r*3+c]  = window[r][c].blue;
         end
      end
   end

   bb3_lane u_lane_red (
      .clock (clock),
      .load  (en_s3),
      .taps  (red_taps),
      .avg   (red_avg)
   );

   bb3_lane u_lane_green (
      .clock (clock),
      .load  (en_s3),
      .taps  (green_taps),
      .avg   (green_avg)
   );

   bb3_lane u_lane_blue (
      .clock (clock),
      .load  (en_s3),
      .taps  (blue_taps),
      .avg   (blue_avg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en_s3) begin
         s3_valid_ff <= s2_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s3) begin
         s3_row_end_ff   <= s2_ctl.row_end;
         s3_frame_end_ff <= s2_ctl.frame_end;
      end
   end

   // merge the lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && s3_valid_ff) begin
         rsp_data_ff.red_out   <= red_avg;
         rsp_data_ff.green_out <= green_avg;
         rsp_data_ff.blue_out  <= blue_avg;
         rsp_data_ff.row_end   <= s3_row_end_ff;
         rsp_data_ff.frame_end <= s3_frame_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_ram.sv
`default_nettype none

module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_window.sv
`default_nettype none

module bb3_window
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_payload_type   req_data,
   input  wire logic [DIM_W-1:0]  line_width,
   input  wire logic [DIM_W-1:0]  frame_height,
   input  wire logic              s2_take,
   output stage_ctl_type          s2_ctl,
   output window_type             window
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;

   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [AW-1:0]    cur_col;
   logic [ROW_W-1:0] cur_row;
   logic [CMPW-1:0]  col_inc;
   logic [DIM_W-1:0] row_inc;
   logic             last_col, last_row, emit;
   logic             accept, en_s1, en_s2;

   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic             s1_last_col_ff;
   logic             s1_last_row_ff;
   logic [AW-1:0]    s1_addr_ff;
   rgb_type          s1_pix_ff;
   logic             s1_byp_ff;
   rgb_type          s1_byp_top_ff;
   rgb_type          s1_byp_mid_ff;

   logic [23:0]      older_rd, newer_rd;
   rgb_type          s1_top, s1_mid;
   logic             line_wr;
   logic             byp_in;

   stage_ctl_type    s2_ctl_ff;
   window_type       window_ff, window_in;

   assign en_s2     = !s2_ctl_ff.valid || s2_take;
   assign en_s1     = !s1_valid_ff || en_s2;
   assign req_ready = en_s1;
   assign accept    = req_valid && en_s1;
   assign line_wr   = s1_valid_ff && en_s2;

   // position of the incoming pixel
   always_comb begin
      cur_col  = req_data.start_of_frame ? '0 : col_ff;
      cur_row  = req_data.start_of_frame ? '0 : row_ff;
      col_inc  = CMPW'(cur_col) + CMPW'(1);
      row_inc  = DIM_W'(cur_row) + DIM_W'(1);
      last_col = (col_inc >= CMPW'(MAX_WIDTH))
              || ((col_inc >= CMPW'(line_width)) && (col_inc >= CMPW'(MIN_DIM)));
      last_row = (row_inc >= DIM_W'(MAX_HEIGHT))
              || ((row_inc >= frame_height) && (row_inc >= DIM_W'(MIN_DIM)));
      emit     = (cur_col >= AW'(2)) && (cur_row >= ROW_W'(2));
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_in = col_inc[AW-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // same column written by the pixel ahead in this cycle: forward it
   assign byp_in = line_wr && (s1_addr_ff == cur_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en_s1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff     <= emit;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_addr_ff     <= cur_col;
         s1_pix_ff      <= {req_data.red_in, req_data.green_in, req_data.blue_in};
         s1_byp_ff      <= byp_in;
         s1_byp_top_ff  <= s1_mid;
         s1_byp_mid_ff  <= s1_pix_ff;
      end
   end

   assign s1_top = s1_byp_ff ? s1_byp_top_ff : rgb_type'(older_rd);
   assign s1_mid = s1_byp_ff ? s1_byp_mid_ff : rgb_type'(newer_rd);

   bb3_ram #(
      .WIDTH (24),
      .DEPTH (MAX_WIDTH)
   ) u_older (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_mid),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (older_rd)
   );

   bb3_ram #(
      .WIDTH (24),
      .DEPTH (MAX_WIDTH)
   ) u_newer (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (newer_rd)
   );

   always_comb begin
      window_in = window_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
      end
      window_in[0][2] = s1_top;
      window_in[1][2] = s1_mid;
      window_in[2][2] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (line_wr) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (en_s2) begin
         s2_ctl_ff.valid     <= s1_valid_ff && s1_emit_ff;
         s2_ctl_ff.row_end   <= s1_last_col_ff;
         s2_ctl_ff.frame_end <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign s2_ctl = s2_ctl_ff;
   assign window = window_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_lane.sv
`default_nettype none

module bb3_lane
   import bb3_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       load,
   input  wire taps_type   taps,
   output logic [7:0]      avg
);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [2*SUM_W-1:0] prod;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 9; k++) begin
         sum_in = sum_in + SUM_W'(taps[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   // divide by nine through the reciprocal
   assign prod = sum_ff * DIV9_MULT;
   assign avg  = prod[DIV9_SHIFT+7:DIV9_SHIFT];

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_checker.sv
`default_nettype none

module bb3_checker
   import bb3_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rsp_payload_type  rsp_data
);

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.frame_end || rsp_data.row_end))
      else $error("frame_end without row_end");

   // after reset, nothing reaches the output before a pixel has passed the line store, window and lane sum registers
   a_no_early_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("response too soon after reset");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // an idle output always frees the request side
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && $past(!rsp_valid, 2) && $past(!rsp_valid, 3)
         && !$past(reset) && !$past(reset, 2) && !$past(reset, 3) |-> req_ready)
      else $error("request blocked with output drained");

endmodule

bind box_blur_3x3_rgb_core bb3_checker u_bb3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: sim/box_blur_3x3_rgb_core_test.sv
`timescale 1ns / 100ps

module box_blur_3x3_rgb_core_test;
   import bb3_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int WINDOW_SIDE   = 3;
   localparam int WINDOW_AREA   = 9;
   localparam int RANDOM_ITEMS  = 400;
   localparam int MAX_IDLE      = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 8'hFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DIM_W-1:0]      csr_data = '0;

   // predictor copy of the block
   logic [DIM_W-1:0] width_reg  = DIM_RESET;
   logic [DIM_W-1:0] height_reg = DIM_RESET;
   rgb_type older_row [MAX_WIDTH_DEF] = '{default: '0};
   rgb_type newer_row [MAX_WIDTH_DEF] = '{default: '0};
   rgb_type win [WINDOW_SIDE][WINDOW_SIDE] = '{default: '{default: '0}};
   int col_pos = 0;
   int row_pos = 0;
   rsp_payload_type expected_blur [$];

   int   errors = 0;
   int   cycles = 0;
   int   rsp_wait = 0;
   bit   sender_gaps = 1'b1;
   logic receiver_stalls = 1'b1;
   logic hold_active = 1'b0;
   event hold_go;

   box_blur_3x3_rgb_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** box_blur_3x3_rgb_core: FAILED **");
         $finish;
      end
   end

   function automatic int clamp_dim(int v, int hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   // one accepted pixel: update line stores, window and position, queue any average
   function void blur_pixel(req_payload_type px);
      rgb_type pix, top, mid;
      rsp_payload_type res;
      int w, h, c, r, i, k, sum_r, sum_g, sum_b;
      bit last_col, last_row;
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      pix = '{px.red_in, px.green_in, px.blue_in};
      if (px.start_of_frame) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = (col_pos >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_pos;
      r = row_pos;
      top = older_row[c];
      mid = newer_row[c];
      older_row[c] = mid;
      newer_row[c] = pix;
      for (i = 0; i < WINDOW_SIDE; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = pix;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      if (c >= WINDOW_SIDE - 1 && r >= WINDOW_SIDE - 1) begin
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         for (i = 0; i < WINDOW_SIDE; i++) begin
            for (k = 0; k < WINDOW_SIDE; k++) begin
               sum_r += win[i][k].red;
               sum_g += win[i][k].green;
               sum_b += win[i][k].blue;
            end
         end
         res.red_out   = 8'(sum_r / WINDOW_AREA);
         res.green_out = 8'(sum_g / WINDOW_AREA);
         res.blue_out  = 8'(sum_b / WINDOW_AREA);
         res.row_end   = last_col;
         res.frame_end = last_col && last_row;
         expected_blur.push_back(res);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function void check_blur(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_blur.size() == 0) begin
         $display("%0t: unexpected result, expected none, got %h", $time, got);
         errors++;
         return;
      end
      want = expected_blur.pop_front();
      if (got.red_out !== want.red_out) begin
         $display("%0t: red_out expected %0d, got %0d", $time, want.red_out, got.red_out);
         errors++;
      end
      if (got.green_out !== want.green_out) begin
         $display("%0t: green_out expected %0d, got %0d", $time, want.green_out,
                  got.green_out);
         errors++;
      end
      if (got.blue_out !== want.blue_out) begin
         $display("%0t: blue_out expected %0d, got %0d", $time, want.blue_out, got.blue_out);
         errors++;
      end
      if (got.row_end !== want.row_end) begin
         $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, got.row_end);
         errors++;
      end
      if (got.frame_end !== want.frame_end) begin
         $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                  got.frame_end);
         errors++;
      end
   endfunction

   // result side: random stall after each result while receiver_stalls is set, plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_blur(rsp_data);
            rsp_wait = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0) && !hold_active;
      end
   end

   initial begin
      forever begin
         @(hold_go);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_payload_type make_pixel(bit sof);
      return '{pick_level(), pick_level(), pick_level(), sof};
   endfunction

   task send_pixel(input req_payload_type px);
      int gap;
      gap = sender_gaps ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      blur_pixel(px);
   endtask

   // noisy: occasional stray start_of_frame inside the stream
   task send_pixels(input int count, input bit sof_first, input bit noisy);
      int i;
      bit sof;
      for (i = 0; i < count; i++) begin
         sof = (i == 0 && sof_first) || (noisy && $urandom_range(0, 49) == 0);
         send_pixel(make_pixel(sof));
      end
   endtask

   task wait_results();
      req_valid <= 1'b0;
      while (expected_blur.size() != 0) @(posedge clock);
   endtask

   // no result pending and pipeline flushed of pixels that make none
   task settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value,
                  input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_LINE_WIDTH)
         width_reg = value;
      else if (idx == CSR_FRAME_HEIGHT)
         height_reg = value;
      if (last)
         csr_valid <= 1'b0;
   endtask

   task set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      settle();
      write_csr(CSR_LINE_WIDTH, w, 1'b0);
      write_csr(CSR_FRAME_HEIGHT, h, 1'b1);
   endtask

   // reset dimensions, counters from reset; first request has no start mark
   task test_reset_defaults();
      send_pixels(WINDOW_SIDE * MAX_WIDTH_DEF, 1'b0, 1'b0);
   endtask

   task test_extremes();
      int i;
      set_dims(DIM_W'(MIN_DIM), DIM_W'(MIN_DIM));
      for (i = 0; i < WINDOW_AREA; i++)
         send_pixel('{8'hFF, 8'hFF, 8'hFF, i == 0});
      // next frame follows the wrap with no start mark
      for (i = 0; i < WINDOW_AREA; i++)
         send_pixel('{8'h00, 8'h00, 8'h00, 1'b0});
      // sums just short of a multiple of nine
      for (i = 0; i < WINDOW_AREA; i++)
         send_pixel('{(i == 4) ? 8'hFE : 8'hFF, (i == 8) ? 8'h08 : 8'h00,
                      (i == 0) ? 8'h11 : 8'h01, i == 0});
   endtask

   task test_clamping();
      set_dims(9'd0, 9'd2);
      send_pixels(WINDOW_AREA, 1'b1, 1'b0);
      set_dims(9'd2, 9'd1);
      write_csr(CSR_UNMAPPED, 9'h1FF, 1'b1);
      send_pixels(WINDOW_AREA, 1'b1, 1'b0);
      set_dims(9'd1, 9'd0);
      send_pixels(WINDOW_AREA, 1'b1, 1'b0);
      set_dims(9'd511, 9'd3);
      send_pixels(WINDOW_SIDE * MAX_WIDTH_DEF, 1'b1, 1'b0);
      // height clamps to the maximum; run one row past the frame end
      set_dims(9'd3, 9'd300);
      send_pixels((MAX_HEIGHT + 1) * MIN_DIM, 1'b0, 1'b0);
   endtask

   task test_midframe();
      int i;
      set_dims(9'd8, 9'd8);
      send_pixels(29, 1'b1, 1'b0);
      for (i = 0; i < 8; i++) begin
         set_dims(DIM_W'($urandom_range(3, 10)), DIM_W'($urandom_range(3, 10)));
         send_pixels($urandom_range(5, 30), 1'b0, 1'b0);
      end
   endtask

   // sink holds off while requests keep coming, so req_ready has to drop
   task test_backpressure();
      set_dims(9'd12, 9'd12);
      sender_gaps = 1'b0;
      -> hold_go;
      send_pixels(144, 1'b1, 1'b0);
      sender_gaps = 1'b1;
   endtask

   task test_drain_pause();
      set_dims(9'd5, 9'd6);
      send_pixels(15, 1'b1, 1'b0);
      wait_results();
      send_pixels(15, 1'b0, 1'b0);
   endtask

   task test_random();
      int sent, count;
      logic [DIM_W-1:0] w, h;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 511))
                                         : DIM_W'($urandom_range(3, 16));
         h = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 511))
                                         : DIM_W'($urandom_range(3, 10));
         set_dims(w, h);
         sender_gaps = ($urandom_range(0, 3) != 0);
         receiver_stalls <= ($urandom_range(0, 3) != 0);
         count = $urandom_range(8, 60);
         send_pixels(count, $urandom_range(0, 7) != 0, 1'b1);
         sent += count;
      end
      sender_gaps = 1'b1;
      receiver_stalls <= 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extremes();
      test_clamping();
      test_midframe();
      test_backpressure();
      test_drain_pause();
      test_random();
      settle();
      if (errors == 0 && expected_blur.size() == 0)
         $display("** box_blur_3x3_rgb_core: PASSED **");
      else
         $display("** box_blur_3x3_rgb_core: FAILED **");
      $finish;
   end

endmodule

FILE: box_blur_3x3_rgb_core.f
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_ram.sv
hw/rtl/bb3_window.sv
hw/rtl/bb3_lane.sv
hw/rtl/box_blur_3x3_rgb_core.sv
hw/rtl/bb3_checker.sv
sim/box_blur_3x3_rgb_core_test.sv
